>>> sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic [31:0] HdrBytes   = 32'd24;
  localparam logic [31:0] MinPayload = 32'd8;
  localparam logic [32:0] LimitBytes = 33'h0_3FFF_FFFF;

  typedef enum logic [1:0] {
    F_ALLOC = 2'd0,
    F_FREE  = 2'd1,
    F_ADD   = 2'd2,
    F_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_BADPTR = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_LARGE  = 3'd4,
    ST_FULL   = 3'd5,
    ST_SMALL  = 3'd6,
    ST_RSVD   = 3'd7
  } status_e;

  // per-cell command for one cycle
  typedef enum logic [1:0] {
    C_HOLD       = 2'd0,
    C_TAKE_LEFT  = 2'd1,
    C_TAKE_RIGHT = 2'd2,
    C_WRITE      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic        valid;
    logic        used;
    logic [31:0] start;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic fit;
    logic eq;
    logic lt;
  } flags_t;

endpackage

>>> sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One table slot: holds a block, shifts to or from its neighbors and
// compares itself against the broadcast search keys.
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffba_pkg::cmd_e   cmd_i,
  input  ffba_pkg::entry_t wr_i,
  input  ffba_pkg::entry_t left_i,
  input  ffba_pkg::entry_t right_i,
  input  logic [31:0]     key_i,
  input  logic [32:0]     need_i,
  output ffba_pkg::entry_t ent_o,
  output ffba_pkg::flags_t flags_o
);
  import ffba_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    case (cmd_i)
      C_HOLD:       ent_d = ent_q;
      C_TAKE_LEFT:  ent_d = left_i;
      C_TAKE_RIGHT: ent_d = right_i;
      C_WRITE:      ent_d = wr_i;
      default:      ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o       = ent_q;
  assign flags_o.fit = ent_q.valid && !ent_q.used && ({1'b0, ent_q.payload} >= need_i);
  assign flags_o.eq  = ent_q.valid && (ent_q.start == key_i);
  assign flags_o.lt  = ent_q.start < key_i;

endmodule

>>> sv/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over an address-sorted chain of block cells, with
// splitting on allocate and merging of free neighbors on release and add.
// ----------------------------------------------------------------------------
//  channel  | handshake        | ports
//  command  | start && !busy   | func_i, length_i, address_i
//  result   | done_o strobe    | status_o, pointer_o, total_bytes_o, used_bytes_o
//
// from accept to the next possible accept: early rejects go to result, then idle;
// allocate and a failed release run scan, update, result, idle; a split
// allocate adds split after update; release and add region run scan, update,
// merge with next, merge with previous, result, idle
// all cells compare in parallel; inserts and removals shift the chain by one
// reset clears the table cells and counters, no clearing pass
// done_o is high for one cycle; the receiver cannot stall it
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] length_i,
  input  logic [31:0] address_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] pointer_o,
  output logic [31:0] total_bytes_o,
  output logic [31:0] used_bytes_o
);
  import ffba_pkg::*;

  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_MNEXT = 7'b0001000,
    S_MPREV = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPLIT = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         key_q, key_d;
  logic [32:0]         need_q, need_d;
  logic [MAX_BLOCKS-1:0] pos_q, pos_d;
  logic                any_q, any_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [31:0]         region_q, region_d;
  logic [31:0]         inuse_q, inuse_d;
  status_e             status_q, status_d;
  logic [31:0]         ptr_q, ptr_d;

  entry_t              ents [MAX_BLOCKS];
  flags_t              flags [MAX_BLOCKS];
  cmd_e                cmds [MAX_BLOCKS];
  entry_t              wr;

  // cell chain
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    entry_t lft, rgt;
    if (g == 0) begin : g_lo
      assign lft = '0;
    end else begin : g_lm
      assign lft = ents[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_hi
      assign rgt = '0;
    end else begin : g_hm
      assign rgt = ents[g+1];
    end
    ffba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmds[g]),
      .wr_i    (wr),
      .left_i  (lft),
      .right_i (rgt),
      .key_i   (key_q),
      .need_i  (need_q),
      .ent_o   (ents[g]),
      .flags_o (flags[g])
    );
  end

  // search vector and first hit
  logic [MAX_BLOCKS-1:0] hits, first;
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      case (func_q)
        F_ALLOC: hits[i] = flags[i].fit;
        F_FREE:  hits[i] = flags[i].eq;
        F_ADD: begin
          if (i == 0) hits[i] = !ents[i].valid || (!flags[i].lt && !flags[i].eq);
          else        hits[i] = !ents[i].valid || !flags[i].lt;
        end
        default: hits[i] = 1'b0;
      endcase
    end
  end
  assign first = hits & (~hits + 1'b1);

  // position masks and reads of the current cell and its neighbors
  logic [MAX_BLOCKS-1:0] ge_m, gt_m, nxt_m, prv_m;
  assign ge_m  = ~(pos_q - 1'b1);
  assign gt_m  = ge_m & ~pos_q;
  assign nxt_m = pos_q << 1;
  assign prv_m = pos_q >> 1;

  entry_t cur, nxt, prv;
  always_comb begin
    cur = '0;
    nxt = '0;
    prv = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      cur = cur | (ents[i] & {$bits(entry_t){pos_q[i]}});
      nxt = nxt | (ents[i] & {$bits(entry_t){nxt_m[i]}});
      prv = prv | (ents[i] & {$bits(entry_t){prv_m[i]}});
    end
  end

  logic [32:0] cur_end, prv_end, room, need_in;
  assign cur_end = {1'b0, cur.start} + {1'b0, HdrBytes} + {1'b0, cur.payload};
  assign prv_end = {1'b0, prv.start} + {1'b0, HdrBytes} + {1'b0, prv.payload};
  assign room    = 33'h1_0000_0000 - {1'b0, address_i};
  assign need_in = ({1'b0, length_i} + 33'd7) & ~33'd7;

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    len_d    = len_q;
    key_d    = key_q;
    need_d   = need_q;
    pos_d    = pos_q;
    any_d    = any_q;
    count_d  = count_q;
    region_d = region_q;
    inuse_d  = inuse_q;
    status_d = status_q;
    ptr_d    = ptr_q;
    wr       = cur;
    for (int i = 0; i < MAX_BLOCKS; i++) cmds[i] = C_HOLD;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d   = func_e'(func_i);
          status_d = ST_OK;
          ptr_d    = '0;
          need_d   = (length_i == '0) ? {1'b0, MinPayload} : need_in;
          len_d    = ({1'b0, length_i} > room) ? room[31:0] : length_i;
          key_d    = (func_i == F_FREE) ? address_i - HdrBytes : address_i;
          state_d  = S_SCAN;
          case (func_e'(func_i))
            F_ALLOC: begin
              if (need_d > LimitBytes) begin
                status_d = ST_LARGE;
                state_d  = S_DONE;
              end
            end
            F_FREE: begin
              if (address_i == '0) begin
                state_d = S_DONE;
              end else if (address_i[2:0] != 3'd0 || address_i < HdrBytes) begin
                status_d = ST_BADPTR;
                state_d  = S_DONE;
              end
            end
            F_ADD: begin
              if (address_i == '0) begin
                status_d = ST_BADPTR;
                state_d  = S_DONE;
              end else if (len_d < HdrBytes + MinPayload) begin
                status_d = ST_SMALL;
                state_d  = S_DONE;
              end else if (count_q >= CntMax) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        pos_d   = first;
        any_d   = |hits;
        state_d = S_EXEC;
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (func_q)
          F_ALLOC: begin
            if (!any_q) begin
              status_d = ST_NOFIT;
            end else begin
              ptr_d    = cur.start + HdrBytes;
              wr.used  = 1'b1;
              if ({1'b0, cur.payload} >= need_q + {1'b0, HdrBytes + MinPayload}
                  && count_q < CntMax) begin
                // the next cell gets a copy of the old block, trimmed next cycle
                wr.payload = need_q[31:0];
                inuse_d    = inuse_q + HdrBytes + need_q[31:0];
                count_d    = count_q + 1'b1;
                pos_d      = nxt_m;
                state_d    = S_SPLIT;
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                  if (pos_q[i])     cmds[i] = C_WRITE;
                  else if (gt_m[i]) cmds[i] = C_TAKE_LEFT;
                end
              end else begin
                inuse_d = inuse_q + HdrBytes + cur.payload;
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                  if (pos_q[i]) cmds[i] = C_WRITE;
                end
              end
            end
          end
          F_FREE: begin
            if (!any_q) begin
              status_d = ST_BADPTR;
            end else if (!cur.used) begin
              status_d = ST_DOUBLE;
            end else begin
              wr.used = 1'b0;
              inuse_d = inuse_q - HdrBytes - cur.payload;
              state_d = S_MNEXT;
              for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (pos_q[i]) cmds[i] = C_WRITE;
              end
            end
          end
          F_ADD: begin
            wr.valid   = 1'b1;
            wr.used    = 1'b0;
            wr.start   = key_q;
            wr.payload = len_q - HdrBytes;
            count_d    = count_q + 1'b1;
            region_d   = region_q + len_q;
            state_d    = S_MNEXT;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
              if (pos_q[i])     cmds[i] = C_WRITE;
              else if (gt_m[i]) cmds[i] = C_TAKE_LEFT;
            end
          end
          default: state_d = S_DONE;
        endcase
      end

      S_SPLIT: begin
        // turn the copied block into the free remainder
        state_d    = S_DONE;
        wr.used    = 1'b0;
        wr.start   = cur.start + HdrBytes + need_q[31:0];
        wr.payload = cur.payload - need_q[31:0] - HdrBytes;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          if (pos_q[i]) cmds[i] = C_WRITE;
        end
      end

      S_MNEXT: begin
        state_d = S_MPREV;
        if (nxt.valid && !nxt.used && cur_end == {1'b0, nxt.start}) begin
          wr.payload = cur.payload + HdrBytes + nxt.payload;
          count_d    = count_q - 1'b1;
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (pos_q[i])     cmds[i] = C_WRITE;
            else if (gt_m[i]) cmds[i] = C_TAKE_RIGHT;
          end
        end
      end

      S_MPREV: begin
        state_d = S_DONE;
        if (prv.valid && !prv.used && prv_end == {1'b0, cur.start}) begin
          wr         = prv;
          wr.payload = prv.payload + HdrBytes + cur.payload;
          count_d    = count_q - 1'b1;
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (prv_m[i])     cmds[i] = C_WRITE;
            else if (ge_m[i]) cmds[i] = C_TAKE_RIGHT;
          end
        end
      end

      S_DONE: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      region_q <= '0;
      inuse_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      region_q <= region_d;
      inuse_q  <= inuse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    len_q    <= len_d;
    key_q    <= key_d;
    need_q   <= need_d;
    pos_q    <= pos_d;
    any_q    <= any_d;
    status_q <= status_d;
    ptr_q    <= ptr_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign pointer_o     = ptr_q;
  assign total_bytes_o = region_q;
  assign used_bytes_o  = inuse_q;

endmodule

>>> sv/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator's command and result behavior.
// ----------------------------------------------------------------------------
module ffba_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [31:0] pointer_o
);
  import ffba_pkg::*;

  // a word is only reported while the command is still owned
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result outside a busy command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> pointer_o == '0)
    else $error("pointer on failed command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != ST_RSVD)
    else $error("reserved status code");

endmodule

bind first_fit_block_allocator_core ffba_port_checker u_ffba_port_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .status_o  (status_o),
  .pointer_o (pointer_o)
);
